### src/ede_pkg.sv
// ede_pkg: shared types and constants of the Euclidean distance engine.
// No dependencies.
`default_nettype none
package ede_pkg;

    localparam int IDX_W    = 10;
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = COORD_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int DIST_W   = 25;
    localparam int REM_W    = DIST_W + 2;
    localparam int ITER_W   = 5;
    localparam int ROOT_STEPS = SUM_W / 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FIRST  = 2'd1,
        ST_SECOND = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [MAG_W-1:0]   ux;
        logic [MAG_W-1:0]   uy;
    } op_t;

    typedef struct packed {
        logic push;
        op_t  data;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
        op_t  data;
    } q_stat_t;

endpackage
`default_nettype wire

### src/ede_ram.sv
// ede_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/ede_front.sv
// ede_front: accepts items, clears the valid map after reset, performs loads,
// reads both points of a query and pushes the difference magnitudes. Uses ede_pkg, ede_ram.
`default_nettype none
module ede_front
    import ede_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      command,
    input  wire logic [IDX_W-1:0]          first_index,
    input  wire logic [IDX_W-1:0]          second_index,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    output logic                           busy,
    input  wire logic                      q_full,
    output q_push_t                        q_push
);

    localparam int ADDR_W = $clog2(MAX_POINTS);

    typedef enum logic [4:0] {
        F_CLEAR = 5'b00001,
        F_IDLE  = 5'b00010,
        F_RD_A  = 5'b00100,
        F_RD_B  = 5'b01000,
        F_PUSH  = 5'b10000
    } fstate_t;

    fstate_t                    state_reg, state_next;
    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]          b_addr_reg, b_addr_next;
    logic                       a_in_reg, a_in_next;
    logic                       b_in_reg, b_in_next;
    logic                       va_reg, va_next;
    logic signed [COORD_W-1:0]  xa_reg, xa_next;
    logic signed [COORD_W-1:0]  ya_reg, ya_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next;
    logic signed [DIFF_W-1:0]   dy_reg, dy_next;
    status_t                    status_reg, status_next;

    logic [31:0]            a_ext, b_ext;
    logic                   a_in, b_in;
    logic [ADDR_W-1:0]      a_addr, b_addr;
    logic                   accept;
    logic                   coord_we, valid_we, valid_wdata;
    logic [ADDR_W-1:0]      valid_waddr, raddr;
    logic [2*COORD_W-1:0]   coord_rdata;
    logic [0:0]             valid_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [DIFF_W-1:0]  ax, ay;

    assign a_ext  = {{(32-IDX_W){1'b0}}, first_index};
    assign b_ext  = {{(32-IDX_W){1'b0}}, second_index};
    assign a_in   = a_ext < 32'(MAX_POINTS);
    assign b_in   = b_ext < 32'(MAX_POINTS);
    assign a_addr = a_ext[ADDR_W-1:0];
    assign b_addr = b_ext[ADDR_W-1:0];

    assign busy   = (state_reg != F_IDLE) || q_full;
    assign accept = start && !busy;

    assign coord_we    = accept && (command == CMD_LOAD) && a_in;
    assign valid_we    = (state_reg == F_CLEAR) || coord_we;
    assign valid_waddr = (state_reg == F_CLEAR) ? clr_cnt_reg : a_addr;
    assign valid_wdata = (state_reg != F_CLEAR);
    assign raddr       = (state_reg == F_RD_A) ? b_addr_reg : a_addr;

    assign rd_x = coord_rdata[COORD_W-1:0];
    assign rd_y = coord_rdata[2*COORD_W-1:COORD_W];

    ede_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_coord_ram (
        .clk   (clk),
        .we    (coord_we),
        .waddr (a_addr),
        .wdata ({coord_y, coord_x}),
        .raddr (raddr),
        .rdata (coord_rdata)
    );

    ede_ram #(
        .WIDTH (1),
        .DEPTH (MAX_POINTS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (valid_we),
        .waddr (valid_waddr),
        .wdata (valid_wdata),
        .raddr (raddr),
        .rdata (valid_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        b_addr_next  = b_addr_reg;
        a_in_next    = a_in_reg;
        b_in_next    = b_in_reg;
        va_next      = va_reg;
        xa_next      = xa_reg;
        ya_next      = ya_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        status_next  = status_reg;
        q_push.push  = 1'b0;
        q_push.data.status = status_reg;
        ax = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
        ay = dy_reg[DIFF_W-1] ? -dy_reg : dy_reg;
        q_push.data.ux = ax[MAG_W-1:0];
        q_push.data.uy = ay[MAG_W-1:0];
        case (state_reg)
            F_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAX_POINTS - 1))
                begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                if (accept && (command == CMD_QUERY))
                begin
                    b_addr_next = b_addr;
                    a_in_next   = a_in;
                    b_in_next   = b_in;
                    state_next  = F_RD_A;
                end
            end
            F_RD_A:
            begin
                va_next    = valid_rdata[0];
                xa_next    = rd_x;
                ya_next    = rd_y;
                state_next = F_RD_B;
            end
            F_RD_B:
            begin
                dx_next = DIFF_W'(rd_x) - DIFF_W'(xa_reg);
                dy_next = DIFF_W'(rd_y) - DIFF_W'(ya_reg);
                if (!a_in_reg || !va_reg)
                begin
                    status_next = ST_FIRST;
                end
                else if (!b_in_reg || !valid_rdata[0])
                begin
                    status_next = ST_SECOND;
                end
                else
                begin
                    status_next = ST_OK;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                q_push.push = 1'b1;
                state_next  = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg <= b_addr_next;
        a_in_reg   <= a_in_next;
        b_in_reg   <= b_in_next;
        va_reg     <= va_next;
        xa_reg     <= xa_next;
        ya_reg     <= ya_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        status_reg <= status_next;
    end

endmodule
`default_nettype wire

### src/ede_queue.sv
// ede_queue: two-entry queue of pending distance operations.
// Uses ede_pkg.
`default_nettype none
module ede_queue
    import ede_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  q_push_t      q_push,
    input  wire logic    pop,
    output q_stat_t      q_stat
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign q_stat.data  = entry_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.data;
        end
    end

endmodule
`default_nettype wire

### src/ede_back.sv
// ede_back: squares the differences, takes the floor square root one bit a
// cycle and issues the result strobe. Uses ede_pkg.
`default_nettype none
module ede_back
    import ede_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  q_stat_t             q_stat,
    output logic                pop,
    output logic                done,
    output logic [DIST_W-1:0]   distance,
    output logic [1:0]          status
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SQX  = 6'b000010,
        B_SQY  = 6'b000100,
        B_SUM  = 6'b001000,
        B_ROOT = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t            state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SQ_W-1:0]    sqx_reg, sqx_next;
    logic [SQ_W-1:0]    sqy_reg, sqy_next;
    logic [SUM_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]  root_reg, root_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;

    logic [REM_W+1:0]   rem_sh, trial;

    assign done     = (state_reg == B_OUT);
    assign distance = root_reg;
    assign status   = op_reg.status;

    assign rem_sh = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        iter_next  = iter_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop       = 1'b1;
                    op_next   = q_stat.data;
                    root_next = '0;
                    state_next = (q_stat.data.status == ST_OK) ? B_SQX : B_OUT;
                end
            end
            B_SQX:
            begin
                sqx_next   = SQ_W'(op_reg.ux) * SQ_W'(op_reg.ux);
                state_next = B_SQY;
            end
            B_SQY:
            begin
                sqy_next   = SQ_W'(op_reg.uy) * SQ_W'(op_reg.uy);
                state_next = B_SUM;
            end
            B_SUM:
            begin
                rad_next   = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
                rem_next   = '0;
                root_next  = '0;
                iter_next  = '0;
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[DIST_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[REM_W-1:0];
                    root_next = {root_reg[DIST_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_STEPS - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
    end

endmodule
`default_nettype wire

### src/euclidean_distance_engine_top.sv
// euclidean_distance_engine_top: point store with pairwise distance queries.
// Uses ede_pkg, ede_front, ede_queue, ede_back.
//
//  channel   ports                                                    handshake
//  item in   command first_index second_index coord_x coord_y         start & !busy
//  result    distance status                                          done, one cycle
//
// A load writes the point store when accepted. A query passes the front states RD_A,
// RD_B and PUSH (two RAM reads), then the back: pop, two squares, sum, 25 root steps,
// strobe. The root loop sets the sustained rate; the back takes one query at a time.
// After reset busy stays high while the valid map clears all MAX_POINTS entries.
// busy also rises while the two-entry queue is full; results cannot be held off.
`default_nettype none
module euclidean_distance_engine_top
    import ede_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      command,
    input  wire logic [IDX_W-1:0]          first_index,
    input  wire logic [IDX_W-1:0]          second_index,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    output logic                           done,
    output logic [DIST_W-1:0]              distance,
    output logic [1:0]                     status
);

    q_push_t q_push;
    q_stat_t q_stat;
    logic    pop;

    ede_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .first_index  (first_index),
        .second_index (second_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .busy         (busy),
        .q_full       (q_stat.full),
        .q_push       (q_push)
    );

    ede_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_stat (q_stat)
    );

    ede_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop      (pop),
        .done     (done),
        .distance (distance),
        .status   (status)
    );

endmodule
`default_nettype wire

### dv/tb.sv
// tb: self-checking testbench for euclidean_distance_engine_top (loads and distance queries).
// Depends on ede_pkg and the engine RTL; a clocked driver and monitor check every result
// against an in-bench predictor of the point store.
module tb;
    import ede_pkg::*;

    localparam int N_POINTS   = 1024;
    localparam int IDLE_LIMIT = 6000;
    localparam int N_RANDOM   = 1725;

    typedef struct {
        logic                      cmd;
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        int                        gap;
        bit                        drain;
    } cmd_item_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        status_t           st;
    } dist_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      command = 1'b0;
    logic [IDX_W-1:0]          first_index = '0;
    logic [IDX_W-1:0]          second_index = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic                      busy;
    logic                      done;
    logic [DIST_W-1:0]         distance;
    logic [1:0]                status;

    cmd_item_t    pending_items[$];
    dist_result_t expected_results[$];
    cmd_item_t    cur_item;

    logic [COORD_W-1:0] pt_x [N_POINTS];
    logic [COORD_W-1:0] pt_y [N_POINTS];
    bit                 pt_loaded [N_POINTS];

    bit gen_loaded [N_POINTS];
    int loaded_list[$];
    bit burst_mode = 1'b0;
    bit drain_next = 1'b0;

    int total_items = 0;
    int accepted_count = 0;
    int gap_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    euclidean_distance_engine_top #(
        .MAX_POINTS(N_POINTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .first_index(first_index),
        .second_index(second_index),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .done(done),
        .distance(distance),
        .status(status)
    );

    always #6 clk = ~clk;

    function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] v);
        logic [DIST_W-1:0]   root;
        logic [DIST_W-1:0]   trial;
        logic [2*DIST_W-1:0] wide;
        root = '0;
        for (int i = DIST_W - 1; i >= 0; i--)
        begin
            trial = root;
            trial[i] = 1'b1;
            wide = {{DIST_W{1'b0}}, trial};
            if (wide * wide <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic apply_item(input cmd_item_t it);
        dist_result_t             r;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0]        mx;
        logic [DIFF_W-1:0]        my;
        logic [SUM_W-1:0]         wx;
        logic [SUM_W-1:0]         wy;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.a < N_POINTS)
            begin
                pt_x[it.a] = it.x;
                pt_y[it.a] = it.y;
                pt_loaded[it.a] = 1'b1;
            end
        end
        else
        begin
            r.dist_val = '0;
            r.st = ST_OK;
            if (it.a >= N_POINTS || !pt_loaded[it.a])
                r.st = ST_FIRST;
            else if (it.b >= N_POINTS || !pt_loaded[it.b])
                r.st = ST_SECOND;
            else if (it.a != it.b)
            begin
                dx = {pt_x[it.b][COORD_W-1], pt_x[it.b]} - {pt_x[it.a][COORD_W-1], pt_x[it.a]};
                dy = {pt_y[it.b][COORD_W-1], pt_y[it.b]} - {pt_y[it.a][COORD_W-1], pt_y[it.a]};
                mx = dx[DIFF_W-1] ? -dx : dx;
                my = dy[DIFF_W-1] ? -dy : dy;
                wx = {{(SUM_W-MAG_W){1'b0}}, mx[MAG_W-1:0]};
                wy = {{(SUM_W-MAG_W){1'b0}}, my[MAG_W-1:0]};
                r.dist_val = floor_root(wx * wx + wy * wy);
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic push_item(input logic cmd, input int a, input int b,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        cmd_item_t it;
        it.cmd = cmd;
        it.a = IDX_W'(a);
        it.b = IDX_W'(b);
        it.x = x;
        it.y = y;
        it.gap = burst_mode ? 0 : $urandom_range(0, 16);
        it.drain = drain_next;
        drain_next = 1'b0;
        pending_items.push_back(it);
        total_items++;
        if (cmd == CMD_LOAD && !gen_loaded[a])
        begin
            gen_loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
    endtask

    task automatic push_load(input int a, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        push_item(CMD_LOAD, a, $urandom_range(0, N_POINTS - 1), x, y);
    endtask

    task automatic push_query(input int a, input int b);
        push_item(CMD_QUERY, a, b, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = {1'b0, {(COORD_W-1){1'b1}}};
            1: c = {1'b1, {(COORD_W-1){1'b0}}};
            2, 3, 4: c = COORD_W'($urandom_range(0, 4095) - 2048);
            default: c = COORD_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic int pick_index();
        if ($urandom_range(0, 3) != 0)
            return $urandom_range(0, 31);
        return $urandom_range(0, N_POINTS - 1);
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    always @(posedge clk)
    begin : driver
        bit fired;
        bit hold;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            fired = start && !busy;
            if (fired)
            begin
                apply_item(cur_item);
                accepted_count++;
            end
            hold = start && !fired;
            if (!hold && pending_items.size() > 0 &&
                !(pending_items[0].drain && expected_results.size() > 0))
            begin
                if (gap_count >= pending_items[0].gap)
                begin
                    cur_item = pending_items.pop_front();
                    command <= cur_item.cmd;
                    first_index <= cur_item.a;
                    second_index <= cur_item.b;
                    coord_x <= cur_item.x;
                    coord_y <= cur_item.y;
                    gap_count = 0;
                    hold = 1'b1;
                end
                else
                    gap_count++;
            end
            start <= hold;
        end
    end

    always @(posedge clk)
    begin : monitor
        dist_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatches < 40)
                    $display("%0t unexpected result: expected none, actual distance %0d status %0d",
                             $time, distance, status);
                mismatches++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (distance !== e.dist_val)
                begin
                    if (mismatches < 40)
                        $display("%0t distance mismatch: expected %0d, actual %0d",
                                 $time, e.dist_val, distance);
                    mismatches++;
                end
                if (status !== e.st)
                begin
                    if (mismatches < 40)
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, e.st, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no item accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int a;
        int b;
        // directed: unloaded, extremes, reload, equal indices
        push_query(0, 1);
        push_query(1023, 1023);
        push_load(0, {1'b1, 23'd0}, {1'b1, 23'd0});
        push_query(0, 0);
        push_query(0, 1);
        push_query(1, 0);
        push_load(1023, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}});
        push_query(0, 1023);
        push_query(1023, 0);
        push_load(1, 24'd0, 24'd0);
        push_query(1, 0);
        push_query(0, 1);
        push_load(1, 24'd256, -24'sd256);
        push_query(1, 1023);
        push_query(1, 1);
        push_load(2, {1'b0, {23{1'b1}}}, {1'b1, 23'd0});
        push_query(0, 2);
        push_query(2, 1023);
        push_load(512, 24'h555555, 24'hAAAAAA);
        push_query(512, 1023);
        push_query(2, 512);
        push_query(700, 1023);
        push_query(1023, 700);
        drain_next = 1'b1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (n == 800)
                drain_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30 || loaded_list.size() == 0)
                push_load(pick_index(), rand_coord(), rand_coord());
            else if (r < 85)
                push_query(pick_loaded(), pick_loaded());
            else if (r < 90)
            begin
                a = pick_loaded();
                push_query(a, a);
            end
            else if (r < 95)
            begin
                a = $urandom_range(0, N_POINTS - 1);
                b = pick_loaded();
                if ($urandom_range(0, 1))
                    push_query(a, b);
                else
                    push_query(b, a);
            end
            else
                push_query($urandom_range(0, N_POINTS - 1), $urandom_range(0, N_POINTS - 1));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_count < total_items || expected_results.size() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
